>>> design/cdcw_pkg.sv
// cdcw_pkg: request/result types, limits and calendar tables for the date checker
package cdcw_pkg;

    // limits of an accepted entry
    localparam logic [13:0] YEAR_MIN  = 14'd2020;
    localparam logic [13:0] YEAR_MAX  = 14'd2099;
    localparam logic [13:0] YEAR_BASE = 14'd2000;
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [5:0]  SEC_MAX   = 6'd59;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [4:0]  FEB_LEAP  = 5'd29;

    // one entered date and time
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_req;

    // one check result
    typedef struct packed {
        logic       valid_res;
        logic [2:0] weekday;
        logic [6:0] year_in_century;
        logic [4:0] month_length;
    } t_res;

    // days in a common year, month 1..12
    function automatic logic [4:0] base_month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd2:                  d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:               d = 5'd31;
        endcase
        return d;
    endfunction

    // zeller month term floor(13*(m+1)/5) mod 7, jan/feb taken as months 13/14
    function automatic logic [2:0] zeller_month_term(input logic [3:0] m);
        logic [2:0] t;
        case (m)
            4'd1:    t = 3'd1;
            4'd2:    t = 3'd4;
            4'd3:    t = 3'd3;
            4'd4:    t = 3'd6;
            4'd5:    t = 3'd1;
            4'd6:    t = 3'd4;
            4'd7:    t = 3'd6;
            4'd8:    t = 3'd2;
            4'd9:    t = 3'd5;
            4'd10:   t = 3'd0;
            4'd11:   t = 3'd3;
            4'd12:   t = 3'd5;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    // zeller day code (0 = saturday) to 1 monday .. 7 sunday
    function automatic logic [2:0] zeller_to_iso(input logic [2:0] h);
        logic [2:0] w;
        case (h)
            3'd0:    w = 3'd6;
            3'd1:    w = 3'd7;
            3'd2:    w = 3'd1;
            3'd3:    w = 3'd2;
            3'd4:    w = 3'd3;
            3'd5:    w = 3'd4;
            3'd6:    w = 3'd5;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

endpackage

>>> design/calendar_date_check_and_weekday_top.sv
// calendar_date_check_and_weekday_top: registered date/time check with weekday output
//
//  channel  | ports                   | handshake
//  ---------+-------------------------+--------------------------------------
//  request  | i_req (t_req)           | taken when start high and busy low
//  result   | o_res (t_res), o_valid  | one cycle strobe, always taken
//
// a request is held in the request register, then in the result register, before it shows on o_res
// one request per cycle, back to back; busy is held low since nothing ever stalls
// the check logic sits between the request register and the result register
// synchronous active-low reset clears both valid flags; payload registers are not reset
module calendar_date_check_and_weekday_top
    import cdcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_res o_res
);

    logic r_req_vld;
    logic n_req_vld;
    t_req r_req;
    logic r_res_vld;
    logic n_res_vld;
    t_res r_res;
    t_res n_res;

    assign busy = 1'b0;

    // request register
    assign n_req_vld = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_req_vld) begin
            r_req <= i_req;
        end
    end

    // check logic
    cdcw_core u_core (
        .i_req (r_req),
        .o_res (n_res)
    );

    // result register
    assign n_res_vld = r_req_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_vld) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_res_vld;
    assign o_res   = r_res;

    // a result strobe follows a request passed through the request and result registers
    a_res_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without request");

    // an invalid result is all zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.valid_res) |->
            (o_res.weekday == 3'd0 && o_res.year_in_century == 7'd0
             && o_res.month_length == 5'd0))
        else $error("invalid result carries data");

    // a valid result has a real weekday, month length and year
    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.valid_res) |->
            (o_res.weekday != 3'd0 && o_res.month_length >= 5'd28
             && o_res.year_in_century >= 7'd20 && o_res.year_in_century <= 7'd99))
        else $error("valid result out of range");

    // february 29 is only reported in a leap year
    a_leap_feb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.month_length == FEB_LEAP) |->
            (o_res.year_in_century[1:0] == 2'd0))
        else $error("leap february in a common year");

endmodule

>>> design/cdcw_core.sv
// cdcw_core: combinational range checks, month length and weekday of one request
module cdcw_core
    import cdcw_pkg::*;
(
    input  t_req i_req,
    output t_res o_res
);

    logic       year_ok;
    logic       month_ok;
    logic       time_ok;
    logic       day_ok;
    logic       leap;
    logic [13:0] year_diff;
    logic [6:0] yoff;
    logic [6:0] k;
    logic [4:0] mlen;
    logic [7:0] sum;
    logic [6:0] fold1;
    logic [4:0] fold2;
    logic [3:0] fold3;
    logic [2:0] h;

    // field range checks
    assign year_ok  = (i_req.year >= YEAR_MIN) && (i_req.year <= YEAR_MAX);
    assign month_ok = (i_req.month >= MONTH_MIN) && (i_req.month <= MONTH_MAX);
    assign time_ok  = (i_req.hour <= HOUR_MAX) && (i_req.minute <= MIN_MAX)
                   && (i_req.second <= SEC_MAX);

    // year within the century; inside 2020..2099 a leap year is any multiple of four
    assign year_diff = i_req.year - YEAR_BASE;
    assign yoff      = year_diff[6:0];
    assign leap      = (yoff[1:0] == 2'd0);

    // month length
    always_comb begin
        if (i_req.month == MONTH_FEB && leap) begin
            mlen = FEB_LEAP;
        end else begin
            mlen = base_month_days(i_req.month);
        end
    end

    assign day_ok = (i_req.day != 5'd0) && (i_req.day <= mlen);

    // zeller: century terms j/4 + 5j vanish mod 7 for j = 20
    assign k   = (i_req.month < 4'd3) ? (yoff - 7'd1) : yoff;
    assign sum = {3'd0, i_req.day} + {5'd0, zeller_month_term(i_req.month)}
               + {1'b0, k} + {3'd0, k[6:2]};

    // mod 7 by folding base 64 and base 8 digits, then one compare and subtract
    assign fold1 = {5'd0, sum[7:6]} + {1'b0, sum[5:0]};
    assign fold2 = {1'b0, fold1[6:3]} + {2'd0, fold1[2:0]};
    assign fold3 = {2'd0, fold2[4:3]} + {1'b0, fold2[2:0]};
    assign h     = (fold3 >= 4'd7) ? 3'(fold3 - 4'd7) : fold3[2:0];

    // result, all zero when any check fails
    always_comb begin
        if (year_ok && month_ok && day_ok && time_ok) begin
            o_res.valid_res       = 1'b1;
            o_res.weekday         = zeller_to_iso(h);
            o_res.year_in_century = yoff;
            o_res.month_length    = mlen;
        end else begin
            o_res = '0;
        end
    end

endmodule
